### rtl/rpn_stack_calculator_top_macros.svh
// Assertion macros of the stack calculator top level.
`ifndef RPN_STACK_CALCULATOR_TOP_MACROS_SVH
`define RPN_STACK_CALCULATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define RSC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define RSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rsc_pkg.sv
// Types, codes and microprogram ROM of the stack calculator.
`timescale 1ns / 1ps

package rsc_pkg;

    localparam int WORD_W = 32;
    localparam int UPC_W  = 5;

    typedef enum logic [2:0] {
        REQ_PUSH, REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV, REQ_EMIT, REQ_PRINT, REQ_DUMP
    } req_t;

    typedef enum logic [2:0] {
        KIND_CHAR, KIND_NUM, KIND_DEPTH, KIND_ELEM, KIND_ERR
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE, ERR_UNDER, ERR_OVER, ERR_DIVZ
    } err_t;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER, C_FULL, C_LT2, C_EMPTY, C_NONEMPTY, C_ISDIV, C_BZERO, C_DIVBUSY,
        C_MORE
    } cond_t;

    typedef enum logic [1:0] {RD_NONE, RD_TOP, RD_SECOND, RD_IDX} rd_t;
    typedef enum logic [1:0] {WR_NONE, WR_LIT, WR_RES} wr_t;
    typedef enum logic [1:0] {DEP_HOLD, DEP_INC, DEP_DEC} dep_t;
    typedef enum logic [1:0] {IDX_HOLD, IDX_CLR, IDX_INC} idxop_t;

    typedef enum logic [2:0] {
        OUT_NONE, OUT_HEADER, OUT_ELEM, OUT_POP, OUT_ERR_OVER, OUT_ERR_UNDER, OUT_ERR_DIVZ
    } out_t;

    typedef logic [UPC_W-1:0] upc_t;

    // One control word. A taken jump suppresses all actions of its word.
    typedef struct packed {
        cond_t  cond;
        upc_t   target;
        rd_t    rd;
        wr_t    wr;
        logic   ld_a;
        logic   ld_b;
        logic   ld_r;
        logic   div_go;
        dep_t   dep;
        idxop_t idx;
        out_t   out;
        logic   done;
    } ctrl_t;

    // microprogram addresses
    localparam upc_t UA_PUSH0 = upc_t'(0);
    localparam upc_t UA_PUSH1 = upc_t'(1);
    localparam upc_t UA_AR0   = upc_t'(2);
    localparam upc_t UA_AR1   = upc_t'(3);
    localparam upc_t UA_AR2   = upc_t'(4);
    localparam upc_t UA_AR3   = upc_t'(5);
    localparam upc_t UA_AR4   = upc_t'(6);
    localparam upc_t UA_AR5   = upc_t'(7);
    localparam upc_t UA_DV0   = upc_t'(8);
    localparam upc_t UA_DV1   = upc_t'(9);
    localparam upc_t UA_DV2   = upc_t'(10);
    localparam upc_t UA_PP0   = upc_t'(11);
    localparam upc_t UA_PP1   = upc_t'(12);
    localparam upc_t UA_PP2   = upc_t'(13);
    localparam upc_t UA_DM0   = upc_t'(14);
    localparam upc_t UA_DM1   = upc_t'(15);
    localparam upc_t UA_DM2   = upc_t'(16);
    localparam upc_t UA_DM3   = upc_t'(17);
    localparam upc_t UA_DM4   = upc_t'(18);
    localparam upc_t UA_EOV   = upc_t'(19);
    localparam upc_t UA_EUN   = upc_t'(20);
    localparam upc_t UA_EDZ   = upc_t'(21);
    localparam upc_t UA_LAST  = UA_EDZ;

    // Entry point of each word type
    function automatic upc_t rsc_entry(req_t req);
        upc_t e;
        case (req)
            REQ_PUSH:                          e = UA_PUSH0;
            REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: e = UA_AR0;
            REQ_EMIT, REQ_PRINT:               e = UA_PP0;
            REQ_DUMP:                          e = UA_DM0;
            default:                           e = UA_DM0;
        endcase
        return e;
    endfunction

    // Microprogram ROM
    function automatic ctrl_t rsc_ucode(upc_t upc);
        ctrl_t w;
        w = '{cond: C_NEVER, target: UA_PUSH0, rd: RD_NONE, wr: WR_NONE,
              ld_a: 1'b0, ld_b: 1'b0, ld_r: 1'b0, div_go: 1'b0, dep: DEP_HOLD,
              idx: IDX_HOLD, out: OUT_NONE, done: 1'b0};
        case (upc)
            // push: overflow check, then write at depth
            UA_PUSH0: begin w.cond = C_FULL; w.target = UA_EOV; end
            UA_PUSH1: begin w.wr = WR_LIT; w.dep = DEP_INC; w.done = 1'b1; end
            // binary ops: fetch b then a, compute, write back
            UA_AR0:   begin w.cond = C_LT2; w.target = UA_EUN; end
            UA_AR1:   w.rd = RD_TOP;
            UA_AR2:   begin w.ld_b = 1'b1; w.rd = RD_SECOND; end
            UA_AR3:   w.ld_a = 1'b1;
            UA_AR4:   begin w.cond = C_ISDIV; w.target = UA_DV0; w.ld_r = 1'b1; end
            UA_AR5:   begin w.wr = WR_RES; w.dep = DEP_DEC; w.done = 1'b1; end
            // division: zero check, run divider, write back
            UA_DV0:   begin w.cond = C_BZERO; w.target = UA_EDZ; w.div_go = 1'b1; end
            UA_DV1:   begin w.cond = C_DIVBUSY; w.target = UA_DV1; w.ld_r = 1'b1; end
            UA_DV2:   begin w.wr = WR_RES; w.dep = DEP_DEC; w.done = 1'b1; end
            // emit / print
            UA_PP0:   begin w.cond = C_EMPTY; w.target = UA_EUN; end
            UA_PP1:   begin w.rd = RD_TOP; w.dep = DEP_DEC; end
            UA_PP2:   begin w.out = OUT_POP; w.done = 1'b1; end
            // dump: header, then bottom to top
            UA_DM0:   begin w.out = OUT_HEADER; w.idx = IDX_CLR; end
            UA_DM1:   begin w.cond = C_NONEMPTY; w.target = UA_DM2; w.done = 1'b1; end
            UA_DM2:   w.rd = RD_IDX;
            UA_DM3:   begin w.out = OUT_ELEM; w.idx = IDX_INC; end
            UA_DM4:   begin w.cond = C_MORE; w.target = UA_DM2; w.done = 1'b1; end
            // error reports
            UA_EOV:   begin w.out = OUT_ERR_OVER; w.done = 1'b1; end
            UA_EUN:   begin w.out = OUT_ERR_UNDER; w.done = 1'b1; end
            UA_EDZ:   begin w.out = OUT_ERR_DIVZ; w.done = 1'b1; end
            default:  w.done = 1'b1;
        endcase
        return w;
    endfunction

endpackage

### rtl/rpn_stack_calculator_top.sv
// Top level of the stack calculator: microcoded sequencer, stack RAM and ALU.
//
//  channel   handshake         fields
//  -------   ---------------   --------------------------------------------
//  request   start / busy      req_type, literal_value
//  result    strobe (1 cycle)  out_kind, out_value, err_code, last_of_run
//
// A word is taken when start is high and busy is low; busy then stays high
// while the microprogram runs. Add/sub/mul fetch b then a from the stack
// RAM; div runs the divider, which makes one quotient bit per cycle; dump
// makes one stack RAM read per element. The single stack RAM read port
// sets the operand fetch steps.
// Reset empties the stack; stack contents need no clearing. Results cannot
// be stalled: each stands on the ports for one cycle with strobe high.
`timescale 1ns / 1ps

module rpn_stack_calculator_top import rsc_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               req_type,
    input  logic signed [WORD_W-1:0] literal_value,
    output logic                     strobe,
    output logic [2:0]               out_kind,
    output logic signed [WORD_W-1:0] out_value,
    output logic [1:0]               err_code,
    output logic                     last_of_run
);

`include "rpn_stack_calculator_top_macros.svh"

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam logic [DEPTH_W-1:0] FULL_LVL = DEPTH_W'(STACK_DEPTH);
    localparam logic [DEPTH_W-1:0] ONE      = DEPTH_W'(1);
    localparam logic [DEPTH_W-1:0] TWO      = DEPTH_W'(2);

    // sequencer state
    logic               run_reg;
    upc_t               upc_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] idx_reg;

    // word and operand registers
    req_t              op_reg;
    logic [WORD_W-1:0] lit_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] r_reg;

    // result registers
    logic              strobe_reg;
    kind_t             kind_reg;
    logic [WORD_W-1:0] value_reg;
    err_t              err_reg;
    logic              last_reg;

    ctrl_t              ctrl;
    logic               accept;
    logic               cond_hit;
    logic               take;
    logic               act;
    logic [DEPTH_W-1:0] depth_m1;
    logic [DEPTH_W-1:0] depth_m2;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [WORD_W-1:0]  rd_data;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic [WORD_W-1:0]  alu;
    logic               div_go;
    logic               div_busy;
    logic [WORD_W-1:0]  quotient;
    kind_t              kind_next;
    logic [WORD_W-1:0]  value_next;
    err_t               err_next;
    logic               last_next;

    assign accept   = start && !run_reg;
    assign ctrl     = rsc_ucode(upc_reg);
    assign depth_m1 = depth_reg - ONE;
    assign depth_m2 = depth_reg - TWO;

    // jump condition
    always_comb
    begin
        case (ctrl.cond)
            C_NEVER:    cond_hit = 1'b0;
            C_FULL:     cond_hit = (depth_reg >= FULL_LVL);
            C_LT2:      cond_hit = (depth_reg < TWO);
            C_EMPTY:    cond_hit = (depth_reg == '0);
            C_NONEMPTY: cond_hit = (depth_reg != '0);
            C_ISDIV:    cond_hit = (op_reg == REQ_DIV);
            C_BZERO:    cond_hit = (b_reg == '0);
            C_DIVBUSY:  cond_hit = div_busy;
            C_MORE:     cond_hit = (idx_reg != depth_reg);
            default:    cond_hit = 1'b0;
        endcase
    end

    assign take = run_reg && cond_hit;
    assign act  = run_reg && !cond_hit;

    // stack RAM addressing
    always_comb
    begin
        case (ctrl.rd)
            RD_TOP:    rd_addr = depth_m1[ADDR_W-1:0];
            RD_SECOND: rd_addr = depth_m2[ADDR_W-1:0];
            RD_IDX:    rd_addr = idx_reg[ADDR_W-1:0];
            default:   rd_addr = '0;
        endcase
    end

    assign rd_en   = act && (ctrl.rd != RD_NONE);
    assign wr_en   = act && (ctrl.wr != WR_NONE);
    assign wr_addr = (ctrl.wr == WR_LIT) ? depth_reg[ADDR_W-1:0] : depth_m2[ADDR_W-1:0];
    assign wr_data = (ctrl.wr == WR_LIT) ? lit_reg : r_reg;

    rsc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // divider
    assign div_go = act && ctrl.div_go;

    rsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (a_reg),
        .divisor  (b_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // ALU, wraps to word width
    always_comb
    begin
        case (op_reg)
            REQ_ADD: alu = a_reg + b_reg;
            REQ_SUB: alu = a_reg - b_reg;
            REQ_MUL: alu = a_reg * b_reg;
            REQ_DIV: alu = quotient;
            default: alu = a_reg + b_reg;
        endcase
    end

    // result formatting
    always_comb
    begin
        kind_next  = KIND_ERR;
        value_next = '0;
        err_next   = ERR_NONE;
        last_next  = 1'b1;
        case (ctrl.out)
            OUT_HEADER:
            begin
                kind_next  = KIND_DEPTH;
                value_next = {{(WORD_W-DEPTH_W){1'b0}}, depth_reg};
                last_next  = (depth_reg == '0);
            end
            OUT_ELEM:
            begin
                kind_next  = KIND_ELEM;
                value_next = rd_data;
                last_next  = ((idx_reg + ONE) == depth_reg);
            end
            OUT_POP:
            begin
                if (op_reg == REQ_EMIT)
                begin
                    kind_next  = KIND_CHAR;
                    value_next = {{(WORD_W-8){1'b0}}, rd_data[7:0]};
                end
                else
                begin
                    kind_next  = KIND_NUM;
                    value_next = rd_data;
                end
            end
            OUT_ERR_OVER:  err_next = ERR_OVER;
            OUT_ERR_UNDER: err_next = ERR_UNDER;
            OUT_ERR_DIVZ:  err_next = ERR_DIVZ;
            default:       last_next = 1'b0;
        endcase
    end

    // sequencer and stack pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            upc_reg    <= UA_PUSH0;
            depth_reg  <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= act && (ctrl.out != OUT_NONE);
            if (accept)
            begin
                run_reg <= 1'b1;
                upc_reg <= rsc_entry(req_t'(req_type));
            end
            else if (take)
            begin
                upc_reg <= ctrl.target;
            end
            else if (act)
            begin
                upc_reg <= upc_reg + upc_t'(1);
                if (ctrl.done)
                begin
                    run_reg <= 1'b0;
                end
                case (ctrl.dep)
                    DEP_INC: depth_reg <= depth_reg + ONE;
                    DEP_DEC: depth_reg <= depth_m1;
                    default: depth_reg <= depth_reg;
                endcase
                case (ctrl.idx)
                    IDX_CLR: idx_reg <= '0;
                    IDX_INC: idx_reg <= idx_reg + ONE;
                    default: idx_reg <= idx_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req_t'(req_type);
            lit_reg <= literal_value;
        end
        if (act && ctrl.ld_b)
        begin
            b_reg <= rd_data;
        end
        if (act && ctrl.ld_a)
        begin
            a_reg <= rd_data;
        end
        if (act && ctrl.ld_r)
        begin
            r_reg <= alu;
        end
        if (act && (ctrl.out != OUT_NONE))
        begin
            kind_reg  <= kind_next;
            value_reg <= value_next;
            err_reg   <= err_next;
            last_reg  <= last_next;
        end
    end

    assign busy        = run_reg;
    assign strobe      = strobe_reg;
    assign out_kind    = kind_reg;
    assign out_value   = value_reg;
    assign err_code    = err_reg;
    assign last_of_run = last_reg;

    // checks
    `RSC_ASSERT_NEXT(a_accept_runs, start && !busy, run_reg,
        "accepted word did not start the sequencer")
    `RSC_ASSERT_SAME(a_depth_bound, 1'b1, depth_reg <= FULL_LVL,
        "stack depth beyond capacity")
    `RSC_ASSERT_SAME(a_err_keeps_stack, strobe_reg && kind_reg == KIND_ERR,
        $stable(depth_reg), "error result changed the stack depth")
    `RSC_ASSERT_SAME(a_div_idle_start, div_go, !div_busy,
        "divider restarted while busy")
    `RSC_ASSERT_SAME(a_upc_range, run_reg, upc_reg <= UA_LAST,
        "microprogram counter left the program")

endmodule

### rtl/rsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/rsc_div.sv
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating.
`timescale 1ns / 1ps

module rsc_div import rsc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              busy,
    output logic [WORD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              neg_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] dvs_reg;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   diff;

    // trial subtract of the shifted remainder
    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(WORD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            busy_reg <= (cnt_reg != CNT_W'(1));
        end
    end

    // datapath on magnitudes; sign applied at the output
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[WORD_W-1] ? (~dividend + WORD_W'(1)) : dividend;
            dvs_reg <= divisor[WORD_W-1] ? (~divisor + WORD_W'(1)) : divisor;
            neg_reg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[WORD_W])
            begin
                rem_reg <= diff[WORD_W-1:0];
            end
            else
            begin
                rem_reg <= shifted[WORD_W-1:0];
            end
            quo_reg <= {quo_reg[WORD_W-2:0], ~diff[WORD_W]};
        end
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? (~quo_reg + WORD_W'(1)) : quo_reg;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the RPN stack calculator: random and directed words.
`timescale 1ns / 1ps

module testbench;
    import rsc_pkg::*;

    localparam int STACK_WORDS = 32;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = 120;

    // One word waiting to be sent, with the sender behavior around it
    typedef struct {
        req_t                     op;
        logic signed [WORD_W-1:0] lit;
        int unsigned              idle_pct;
        bit                       drain;
    } word_t;

    // One expected result
    typedef struct {
        kind_t                    kind;
        logic signed [WORD_W-1:0] value;
        err_t                     err;
        logic                     last;
    } result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [2:0]               req_type = REQ_PUSH;
    logic signed [WORD_W-1:0] literal_value = '0;
    logic                     strobe;
    logic [2:0]               out_kind;
    logic signed [WORD_W-1:0] out_value;
    logic [1:0]               err_code;
    logic                     last_of_run;

    // Stimulus and expectation stores
    word_t   pending_words[$];
    result_t pending_results[$];

    // Predicted calculator state
    logic signed [WORD_W-1:0] calc_stack [STACK_WORDS];
    int                       calc_depth = 0;

    // Generator state: depth estimate, current idle rate, drain request
    int          gen_depth = 0;
    int unsigned cur_idle = 0;
    bit          drain_next = 1'b0;

    bit holding = 1'b0;
    bit word_taken = 1'b0;
    int fail_count = 0;

    rpn_stack_calculator_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .literal_value (literal_value),
        .strobe        (strobe),
        .out_kind      (out_kind),
        .out_value     (out_value),
        .err_code      (err_code),
        .last_of_run   (last_of_run)
    );

    always #4 clk = ~clk;

    function automatic void note_error(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endfunction

    function automatic void post_result(kind_t k, logic signed [WORD_W-1:0] v, err_t e,
                                        logic l);
        pending_results.push_back('{kind: k, value: v, err: e, last: l});
    endfunction

    // Stack calculator predictor: updates the stack and queues the results of one word
    function automatic void exec_word(req_t op, logic signed [WORD_W-1:0] lit);
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
        logic signed [WORD_W-1:0] r;
        longint                   quo;
        case (op)
            REQ_PUSH:
            begin
                if (calc_depth >= STACK_WORDS)
                begin
                    post_result(KIND_ERR, '0, ERR_OVER, 1'b1);
                end
                else
                begin
                    calc_stack[calc_depth] = lit;
                    calc_depth++;
                end
            end
            REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV:
            begin
                if (calc_depth < 2)
                begin
                    post_result(KIND_ERR, '0, ERR_UNDER, 1'b1);
                end
                else
                begin
                    b = calc_stack[calc_depth - 1];
                    a = calc_stack[calc_depth - 2];
                    if (op == REQ_DIV && b == 0)
                    begin
                        post_result(KIND_ERR, '0, ERR_DIVZ, 1'b1);
                    end
                    else
                    begin
                        case (op)
                            REQ_ADD: r = a + b;
                            REQ_SUB: r = a - b;
                            REQ_MUL: r = a * b;
                            default:
                            begin
                                // 64-bit divide so min / -1 wraps instead of trapping
                                quo = longint'(a) / longint'(b);
                                r = quo[WORD_W-1:0];
                            end
                        endcase
                        calc_stack[calc_depth - 2] = r;
                        calc_depth--;
                    end
                end
            end
            REQ_EMIT, REQ_PRINT:
            begin
                if (calc_depth < 1)
                begin
                    post_result(KIND_ERR, '0, ERR_UNDER, 1'b1);
                end
                else
                begin
                    calc_depth--;
                    a = calc_stack[calc_depth];
                    if (op == REQ_EMIT)
                    begin
                        post_result(KIND_CHAR, {24'b0, a[7:0]}, ERR_NONE, 1'b1);
                    end
                    else
                    begin
                        post_result(KIND_NUM, a, ERR_NONE, 1'b1);
                    end
                end
            end
            default:
            begin
                // dump: depth header, then bottom to top
                post_result(KIND_DEPTH, calc_depth, ERR_NONE, calc_depth == 0);
                for (int i = 0; i < calc_depth; i++)
                begin
                    post_result(KIND_ELEM, calc_stack[i], ERR_NONE, i == calc_depth - 1);
                end
            end
        endcase
    endfunction

    function automatic void check_result();
        result_t exp_res;
        if (pending_results.size() == 0)
        begin
            note_error($sformatf("unexpected result kind=%0d value=%0d err=%0d last=%0d",
                                 out_kind, out_value, err_code, last_of_run));
            return;
        end
        exp_res = pending_results.pop_front();
        if (out_kind !== exp_res.kind || out_value !== exp_res.value ||
            err_code !== exp_res.err || last_of_run !== exp_res.last)
        begin
            note_error($sformatf(
                "expected kind=%0d value=%0d err=%0d last=%0d, got kind=%0d value=%0d err=%0d last=%0d",
                exp_res.kind, exp_res.value, exp_res.err, exp_res.last,
                out_kind, out_value, err_code, last_of_run));
        end
    endfunction

    // Generator helpers
    function automatic void queue_word(req_t op, logic signed [WORD_W-1:0] lit);
        pending_words.push_back('{op: op, lit: lit, idle_pct: cur_idle, drain: drain_next});
        drain_next = 1'b0;
        case (op)
            REQ_PUSH:
            begin
                if (gen_depth < STACK_WORDS)
                    gen_depth++;
            end
            REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV:
            begin
                if (gen_depth >= 2)
                    gen_depth--;
            end
            REQ_EMIT, REQ_PRINT:
            begin
                if (gen_depth >= 1)
                    gen_depth--;
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_literal();
        int v;
        case ($urandom_range(9))
            0: v = 0;
            1: v = -1;
            2: v = 32'sh8000_0000;
            3: v = 32'sh7FFF_FFFF;
            4: v = 1;
            5, 6: v = int'($urandom_range(200)) - 100;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Well-formed choice: operands are there and pushes leave room
    function automatic req_t pick_op();
        int unsigned r;
        req_t        op;
        r = $urandom_range(99);
        if (r < 38)
            op = REQ_PUSH;
        else if (r < 76)
            op = req_t'(3'(1 + r % 4));
        else if (r < 84)
            op = REQ_EMIT;
        else if (r < 92)
            op = REQ_PRINT;
        else
            op = REQ_DUMP;
        if ((op >= REQ_ADD && op <= REQ_DIV && gen_depth < 2) ||
            ((op == REQ_EMIT || op == REQ_PRINT) && gen_depth < 1))
            op = REQ_PUSH;
        else if (op == REQ_PUSH && gen_depth >= STACK_WORDS)
            op = REQ_ADD;
        return op;
    endfunction

    // Fill the stack, push once more into a full stack, dump it all
    function automatic void fill_and_dump();
        drain_next = 1'b1;
        while (gen_depth < STACK_WORDS)
        begin
            queue_word(REQ_PUSH, pick_literal());
        end
        queue_word(REQ_PUSH, pick_literal());
        queue_word(REQ_DUMP, $urandom);
    endfunction

    // Monitor: take accepted words into the predictor, check each strobed result
    always @(posedge clk)
    begin : monitor
        if (rst_n)
        begin
            if (strobe)
                check_result();
            if (start && !busy)
            begin
                exec_word(req_t'(req_type), literal_value);
                word_taken = 1'b1;
            end
        end
    end

    // Driver: hold a word on the ports until taken, idle at random between words
    always @(negedge clk)
    begin : driver
        bit    offer;
        word_t nxt;
        offer = 1'b0;
        if (word_taken)
        begin
            word_taken = 1'b0;
            holding = 1'b0;
        end
        if (holding)
        begin
            offer = 1'b1;
        end
        else if (rst_n && pending_words.size() != 0)
        begin
            if (pending_words[0].drain && (pending_results.size() != 0 || busy))
            begin
                offer = 1'b0;
            end
            else if ($urandom_range(99) >= pending_words[0].idle_pct)
            begin
                nxt = pending_words.pop_front();
                req_type <= nxt.op;
                literal_value <= nxt.lit;
                holding = 1'b1;
                offer = 1'b1;
            end
        end
        start <= offer;
    end

    // Stimulus, reset and end of run
    initial
    begin : run_ctrl
        int unsigned phase_idle [4];
        req_t        op;
        phase_idle = '{0, 67, 0, 19};

        // Directed words: empty-stack errors, wraps, divide by zero, every operation
        queue_word(REQ_DUMP, $urandom);
        queue_word(REQ_ADD, $urandom);
        queue_word(REQ_PRINT, $urandom);
        queue_word(REQ_EMIT, $urandom);
        queue_word(REQ_PUSH, 32'sh8000_0000);
        queue_word(REQ_SUB, $urandom);
        queue_word(REQ_PUSH, -1);
        queue_word(REQ_DIV, $urandom);
        queue_word(REQ_PUSH, 0);
        queue_word(REQ_DIV, $urandom);
        queue_word(REQ_DUMP, $urandom);
        queue_word(REQ_PUSH, 32'sh7FFF_FFFF);
        queue_word(REQ_ADD, $urandom);
        queue_word(REQ_ADD, $urandom);
        queue_word(REQ_PUSH, 32'sh7FFF_FFFF);
        queue_word(REQ_MUL, $urandom);
        queue_word(REQ_PUSH, 5);
        queue_word(REQ_SUB, $urandom);
        queue_word(REQ_PUSH, -4);
        queue_word(REQ_DIV, $urandom);
        queue_word(REQ_PUSH, 300);
        queue_word(REQ_EMIT, $urandom);
        queue_word(REQ_EMIT, $urandom);
        queue_word(REQ_DUMP, $urandom);

        // Random phases with varying sender idle rates
        for (int p = 0; p < 4; p++)
        begin
            cur_idle = phase_idle[p];
            drain_next = 1'b1;
            if (p == 1 || p == 3)
                fill_and_dump();
            for (int n = 0; n < 40; n++)
            begin
                if ($urandom_range(99) < 3)
                    drain_next = 1'b1;
                if ($urandom_range(99) < 8)
                    op = req_t'($urandom_range(7));
                else
                    op = pick_op();
                queue_word(op, (op == REQ_PUSH) ? pick_literal() : $signed($urandom));
            end
        end

        // Hold reset, then release it at a falling clock edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || holding || pending_results.size() != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #2_000_000;
        $display("ERROR: run timed out");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/rsc_pkg.sv
rtl/rsc_ram.sv
rtl/rsc_div.sv
rtl/rpn_stack_calculator_top.sv
tb/sv/testbench.sv
